>>> src/scu_pkg.sv
// Shared types, constants and header lookups for the stored certificate unwrapper.
`timescale 1ns / 1ps
package scu_pkg;

  // Widths of the frame tracking state
  localparam int unsigned PosW = 17;
  localparam int unsigned LenW = 16;
  localparam logic [PosW-1:0] PosMax = '1;

  // Byte positions inside the record header
  localparam logic [PosW-1:0] LenHiPos     = 17'd3;
  localparam logic [PosW-1:0] LenLoPos     = 17'd4;
  localparam logic [PosW-1:0] FullHdrPos   = 17'd5;
  localparam logic [PosW-1:0] FullHdrLast  = 17'd6;
  localparam logic [PosW-1:0] HeaderBytes  = 17'd7;
  localparam logic [PosW-1:0] StoredHdrLen = 17'd3;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StTooShort  = 3'd1,
    StBadStored = 3'd2,
    StBadFull   = 3'd3,
    StBadSize   = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_req_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       frame_done;
    status_e    status;
  } out_res_t;

  // Request held in the input register, as seen by the core
  typedef struct packed {
    logic    valid;
    in_req_t req;
  } in_slot_t;

  // Expected stored-cert header byte at position 0..2
  function automatic logic [7:0] stored_hdr_byte(input logic [1:0] sel);
    logic [7:0] val;
    unique case (sel)
      2'd0:    val = 8'h10;
      2'd1:    val = 8'h01;
      2'd2:    val = 8'h00;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // Expected full-cert header byte: first (position 5) or second (position 6)
  function automatic logic [7:0] full_hdr_byte(input logic second);
    logic [7:0] val;
    val = second ? 8'h02 : 8'h10;
    return val;
  endfunction

endpackage

>>> src/scu_in_stage.sv
// Input register that takes one request per cycle while the core keeps accepting, and hands it to the core.
`timescale 1ns / 1ps
module scu_in_stage
  import scu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output in_slot_t slot_o,
  input  logic     slot_ready_i
);

  logic    vld_q, vld_d;
  in_req_t req_q, req_d;
  logic    take;

  // Accept while empty or while the core drains the held request
  assign in_ready_o = !vld_q || slot_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    req_d = req_q;
    if (take) begin
      vld_d = 1'b1;
      req_d = in_req_i;
    end else if (slot_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign slot_o.valid = vld_q;
  assign slot_o.req   = req_q;

endmodule

>>> src/scu_core.sv
// Frame tracking, header checks, payload window and the result register.
`timescale 1ns / 1ps
module scu_core
  import scu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_slot_t slot_i,
  output logic     slot_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_res_t out_res_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [LenW-1:0] len_q, len_d;
  logic            stored_bad_q, stored_bad_d;
  logic            full_bad_q, full_bad_d;
  logic            out_vld_q, out_vld_d;
  out_res_t        res_q, res_d;

  logic            fire;
  logic [PosW-1:0] idx;
  logic [7:0]      b;
  logic            last;
  logic [PosW-1:0] end_pos;
  logic [PosW:0]   n_bytes;
  logic            in_window;

  // Move a request in whenever the result register is free or being drained
  assign slot_ready_o = !out_vld_q || out_ready_i;
  assign fire         = slot_i.valid && slot_ready_o;

  assign idx  = pos_q;
  assign b    = slot_i.req.in_byte;
  assign last = slot_i.req.is_last;

  // Header checks and length capture for the current byte
  always_comb begin
    len_d        = len_q;
    stored_bad_d = stored_bad_q;
    full_bad_d   = full_bad_q;
    if (idx < StoredHdrLen) begin
      if (b != stored_hdr_byte(idx[1:0])) begin
        stored_bad_d = 1'b1;
      end
    end else if (idx == LenHiPos) begin
      len_d = {b, len_q[7:0]};
    end else if (idx == LenLoPos) begin
      len_d = {len_q[15:8], b};
    end else if (idx < HeaderBytes) begin
      if (b != full_hdr_byte(idx == FullHdrLast)) begin
        full_bad_d = 1'b1;
      end
    end
  end

  // Payload window is HeaderBytes <= idx < length + FullHdrPos
  assign end_pos   = {1'b0, len_d} + FullHdrPos;
  assign n_bytes   = {1'b0, idx} + {{PosW{1'b0}}, 1'b1};
  assign in_window = (idx >= HeaderBytes) && (idx < end_pos) && !stored_bad_d && !full_bad_d;

  // Build the result for this byte
  always_comb begin
    res_d.payload_byte  = in_window ? b : 8'h00;
    res_d.payload_valid = in_window;
    res_d.frame_done    = last;
    res_d.status        = StOk;
    if (last) begin
      priority if (n_bytes < {1'b0, HeaderBytes}) begin
        res_d.status = StTooShort;
      end else if (stored_bad_d) begin
        res_d.status = StBadStored;
      end else if (full_bad_d) begin
        res_d.status = StBadFull;
      end else if ({1'b0, end_pos} > n_bytes) begin
        res_d.status = StBadSize;
      end else begin
        res_d.status = StOk;
      end
    end
  end

  // Advance the frame state, clear it after the last byte
  always_comb begin
    pos_d = pos_q;
    if (last) begin
      pos_d = '0;
    end else if (pos_q != PosMax) begin
      pos_d = pos_q + {{(PosW-1){1'b0}}, 1'b1};
    end
  end

  assign out_vld_d = fire ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      len_q        <= '0;
      stored_bad_q <= 1'b0;
      full_bad_q   <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (fire) begin
        pos_q        <= pos_d;
        len_q        <= last ? '0 : len_d;
        stored_bad_q <= last ? 1'b0 : stored_bad_d;
        full_bad_q   <= last ? 1'b0 : full_bad_d;
      end
    end
  end

  // Result payload needs no reset
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = res_q;

  // A finished frame leaves the tracker at the start of a new one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && last |=> (pos_q == '0) && (len_q == '0) && !stored_bad_q && !full_bad_q)
    else $error("frame state not cleared after last byte");

  // Counter steps by one per byte inside a frame until it saturates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !last && (pos_q != PosMax) |=> pos_q == $past(pos_q) + {{(PosW-1){1'b0}}, 1'b1})
    else $error("byte position did not advance");

  // Stored header error can only be raised by one of the first three bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stored_bad_q) |-> $past(pos_q) < StoredHdrLen)
    else $error("stored header flag set outside header");

  // Status is only reported on the last byte of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_q.frame_done |-> res_q.status == StOk)
    else $error("status reported before end of frame");

  // Non-payload results carry a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_q.payload_valid |-> res_q.payload_byte == 8'h00)
    else $error("payload byte leaked outside window");

endmodule

>>> src/stored_cert_unwrapper_top.sv
// Top level of the stored certificate unwrapper: input register and core.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_req_i) takes one byte of a
//   stored certificate record per request; is_last marks the final byte.
//   Output channel (out_valid_o / out_ready_i / out_res_o) gives exactly one
//   result per input byte: the byte with payload_valid when it lies in the
//   certificate body and both headers matched, and frame_done plus a status
//   code on the last byte. On a bad status the consumer drops the payload
//   already delivered for that frame.
//   An accepted byte is held in the input register, then in the result
//   register, from which its result is offered. Throughput: one byte per
//   cycle sustained while the receiver does not stall, set by the
//   combinational header check and window compare between the registers.
//   Reset clears both registers' valid flags and the frame state, so the
//   first byte after reset starts a new frame. When the receiver stalls,
//   the result register holds its result, and the input register takes one
//   more byte only if it was empty; in_ready_o stays low while it holds one.
`timescale 1ns / 1ps
module stored_cert_unwrapper_top
  import scu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_res_t out_res_o
);

  in_slot_t slot;
  logic     slot_ready;

  scu_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .slot_o       (slot),
    .slot_ready_i (slot_ready)
  );

  scu_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .slot_i       (slot),
    .slot_ready_o (slot_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_res_o    (out_res_o)
  );

endmodule
